// ===== rtl/core/vtpc_pkg.sv =====
// Package for the vertex transform / projection / clip block.
// Shared constants, register codes and structs; no dependencies.
`timescale 1ns / 1ps
package vtpc_pkg;

    localparam int SKIN_COORD_BITS = 10;
    localparam int CAM_W           = 24;
    localparam int PROD_W          = 56;
    localparam int DVS_W           = 24;
    localparam int DIV_STAGES      = PROD_W;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_AW         = 2;
    localparam int APB_AW          = 6;
    localparam int APB_DW          = 64;

    // register indexes
    localparam logic [2:0] REG_ROT_X    = 3'd0;
    localparam logic [2:0] REG_ROT_Y    = 3'd1;
    localparam logic [2:0] REG_ROT_Z    = 3'd2;
    localparam logic [2:0] REG_TRANS    = 3'd3;
    localparam logic [2:0] REG_SCALE    = 3'd4;
    localparam logic [2:0] REG_CENTER   = 3'd5;
    localparam logic [2:0] REG_RECT     = 3'd6;
    localparam logic [2:0] REG_NEAR     = 3'd7;

    // 2^35 as dividend for inverse depth
    localparam logic [PROD_W-1:0] INV_DIVIDEND = PROD_W'(64'h8_0000_0000);
    localparam logic [31:0]       U32_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [47:0]        rot_x;
        logic [47:0]        rot_y;
        logic [47:0]        rot_z;
        logic [59:0]        trans;
        logic [63:0]        scale;
        logic [63:0]        center;
        logic [63:0]        rect;
        logic [CAM_W-1:0]   near;
    } cfg_t;

    typedef struct packed {
        logic signed [CAM_W-1:0] cam_x;
        logic signed [CAM_W-1:0] cam_y;
        logic signed [CAM_W-1:0] cam_z;
        logic                    near;
        logic [15:0]             light;
        logic [25:0]             tex_s;
        logic [25:0]             tex_t;
    } item_t;

    typedef struct packed {
        item_t item;
        logic  neg_u;
        logic  neg_v;
        logic  z_neg;
        logic  z_zero;
    } side_t;

endpackage

// ===== rtl/core/vtpc_if.sv =====
// Valid/ready channel interfaces for vertices in and projected vertices out.
// Depends on vtpc_pkg.
`timescale 1ns / 1ps
interface vtpc_in_if;
    import vtpc_pkg::*;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        light_in;
    logic [9:0]         skin_s;
    logic [9:0]         skin_t;
    modport source (output valid, pos_x, pos_y, pos_z, light_in, skin_s, skin_t,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, light_in, skin_s, skin_t,
                    output ready);
endinterface

interface vtpc_out_if;
    import vtpc_pkg::*;
    logic               valid;
    logic               ready;
    logic signed [23:0] cam_x;
    logic signed [23:0] cam_y;
    logic signed [23:0] cam_z;
    logic signed [31:0] screen_u;
    logic signed [31:0] screen_v;
    logic [31:0]        inv_depth;
    logic [4:0]         clip_flags;
    logic [15:0]        light_out;
    logic [25:0]        tex_s;
    logic [25:0]        tex_t;
    modport source (output valid, cam_x, cam_y, cam_z, screen_u, screen_v, inv_depth,
                    clip_flags, light_out, tex_s, tex_t, input ready);
    modport sink   (input valid, cam_x, cam_y, cam_z, screen_u, screen_v, inv_depth,
                    clip_flags, light_out, tex_s, tex_t, output ready);
endinterface

// ===== rtl/core/vtpc_front.sv =====
// Front end: accepts vertices, rotates/translates to camera space, tags near clip.
// Depends on vtpc_pkg and vtpc_in_if.
`timescale 1ns / 1ps
module vtpc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  vtpc_pkg::cfg_t cfg,
    vtpc_in_if.sink        vtx_in,
    input  logic           q_full,
    output logic           push,
    output vtpc_pkg::item_t push_item
);
    import vtpc_pkg::*;

    logic                en;
    logic [47:0]         rows [3];
    logic signed [15:0]  pos [3];
    logic signed [31:0]  prod_reg [3][3];
    logic                f1_valid_reg;
    logic                f2_valid_reg;
    logic [15:0]         f1_light_reg;
    logic [25:0]         f1_tex_s_reg;
    logic [25:0]         f1_tex_t_reg;
    item_t               f2_item_reg;
    item_t               f2_item_next;
    logic signed [37:0]  acc [3];
    logic signed [37:0]  shifted [3];
    logic signed [CAM_W-1:0] cam [3];

    // whole front advances unless the last stage is blocked by a full queue
    assign en           = !f2_valid_reg || !q_full;
    assign vtx_in.ready = en;
    assign push         = f2_valid_reg && !q_full;
    assign push_item    = f2_item_reg;

    assign rows[0] = cfg.rot_x;
    assign rows[1] = cfg.rot_y;
    assign rows[2] = cfg.rot_z;
    assign pos[0]  = vtx_in.pos_x;
    assign pos[1]  = vtx_in.pos_y;
    assign pos[2]  = vtx_in.pos_z;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= vtx_in.valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    // stage 1: nine coefficient products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= $signed(rows[r][16*c +: 16]) * pos[c];
                end
            end
            f1_light_reg <= vtx_in.light_in;
            f1_tex_s_reg <= 26'({vtx_in.skin_s[SKIN_COORD_BITS-1:0], 16'h0000});
            f1_tex_t_reg <= 26'({vtx_in.skin_t[SKIN_COORD_BITS-1:0], 16'h0000});
        end
    end

    // stage 2: sum, round to Q20.4, saturate, near test
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = 38'(prod_reg[r][0]) + 38'(prod_reg[r][1]) + 38'(prod_reg[r][2])
                   + (38'($signed(cfg.trans[20*r +: 20])) <<< 14) + 38'sd8192;
            shifted[r] = acc[r] >>> 14;
            if (shifted[r] > 38'sd8388607)
                cam[r] = 24'sh7FFFFF;
            else if (shifted[r] < -38'sd8388608)
                cam[r] = 24'sh800000;
            else
                cam[r] = shifted[r][CAM_W-1:0];
        end
        f2_item_next.cam_x = cam[0];
        f2_item_next.cam_y = cam[1];
        f2_item_next.cam_z = cam[2];
        f2_item_next.near  = cam[2] < $signed(cfg.near);
        f2_item_next.light = f1_light_reg;
        f2_item_next.tex_s = f1_tex_s_reg;
        f2_item_next.tex_t = f1_tex_t_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            f2_item_reg <= f2_item_next;
    end

endmodule

// ===== rtl/core/vtpc_fifo.sv =====
// Short queue between front and back ends.
// Depends on vtpc_pkg.
`timescale 1ns / 1ps
module vtpc_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vtpc_pkg::item_t push_item,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output vtpc_pkg::item_t head
);
    import vtpc_pkg::*;

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    assign full  = count_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/core/vtpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Depends on vtpc_pkg.
`timescale 1ns / 1ps
module vtpc_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [vtpc_pkg::PROD_W-1:0] dividend,
    input  logic [vtpc_pkg::DVS_W-1:0]  divisor,
    output logic [vtpc_pkg::PROD_W-1:0] quotient
);
    import vtpc_pkg::*;

    logic [DVS_W-1:0]  st_rem [DIV_STAGES+1];
    logic [PROD_W-1:0] st_dq  [DIV_STAGES+1];
    logic [DVS_W-1:0]  st_dvs [DIV_STAGES+1];

    assign st_rem[0] = '0;
    assign st_dq[0]  = dividend;
    assign st_dvs[0] = divisor;
    assign quotient  = st_dq[DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_stage
        logic [DVS_W:0]    trial;
        logic [DVS_W:0]    diff;
        logic              ge;
        logic [DVS_W-1:0]  rem_reg;
        logic [PROD_W-1:0] dq_reg;
        logic [DVS_W-1:0]  dvs_reg;

        // shift in next dividend bit, subtract if it fits
        assign trial = {st_rem[i], st_dq[i][PROD_W-1]};
        assign diff  = trial - {1'b0, st_dvs[i]};
        assign ge    = trial >= {1'b0, st_dvs[i]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                dq_reg  <= {st_dq[i][PROD_W-2:0], ge};
                dvs_reg <= st_dvs[i];
            end
        end

        assign st_rem[i+1] = rem_reg;
        assign st_dq[i+1]  = dq_reg;
        assign st_dvs[i+1] = dvs_reg;
    end

endmodule

// ===== rtl/core/vtpc_back.sv =====
// Back end: projection multiply, divide by depth, centre, saturate, side flags.
// Depends on vtpc_pkg, vtpc_out_if and vtpc_div.
`timescale 1ns / 1ps
module vtpc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  vtpc_pkg::cfg_t  cfg,
    input  logic            q_empty,
    input  vtpc_pkg::item_t q_head,
    output logic            pop,
    vtpc_out_if.source      vtx_out
);
    import vtpc_pkg::*;

    logic                     en;
    logic                     b1_valid_reg;
    item_t                    b1_item_reg;
    logic signed [PROD_W-1:0] mx_reg;
    logic signed [PROD_W-1:0] my_reg;
    logic [PROD_W-1:0]        mag_x;
    logic [PROD_W-1:0]        mag_y;
    logic [DVS_W-1:0]         mag_z;
    side_t                    side_next;
    side_t                    side_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0]    side_valid_reg;
    logic [PROD_W-1:0]        qu;
    logic [PROD_W-1:0]        qv;
    logic [PROD_W-1:0]        qi;
    side_t                    tail;
    logic signed [59:0]       su;
    logic signed [59:0]       sv;
    logic signed [31:0]       u_next;
    logic signed [31:0]       v_next;
    logic [31:0]              inv_next;
    logic                     r1_valid_reg;
    item_t                    r1_item_reg;
    logic signed [31:0]       r1_u_reg;
    logic signed [31:0]       r1_v_reg;
    logic [31:0]              r1_inv_reg;
    logic [4:0]               flags_next;
    logic                     out_valid_reg;

    // whole back end stalls only when the output register is held
    assign en  = !out_valid_reg || vtx_out.ready;
    assign pop = en && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg   <= 1'b0;
            side_valid_reg <= '0;
            r1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg   <= !q_empty;
            side_valid_reg <= {side_valid_reg[DIV_STAGES-2:0], b1_valid_reg};
            r1_valid_reg   <= side_valid_reg[DIV_STAGES-1];
            out_valid_reg  <= r1_valid_reg;
        end
    end

    // stage 1: coordinate times projection scale
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_item_reg <= q_head;
            mx_reg      <= q_head.cam_x * $signed(cfg.scale[31:0]);
            my_reg      <= q_head.cam_y * $signed(cfg.scale[63:32]);
        end
    end

    // magnitudes and quotient signs for the dividers
    always_comb
    begin
        mag_x = mx_reg[PROD_W-1] ? PROD_W'(-mx_reg) : PROD_W'(mx_reg);
        mag_y = my_reg[PROD_W-1] ? PROD_W'(-my_reg) : PROD_W'(my_reg);
        mag_z = b1_item_reg.cam_z[CAM_W-1] ? DVS_W'(-b1_item_reg.cam_z)
                                           : DVS_W'(b1_item_reg.cam_z);
        side_next.item   = b1_item_reg;
        side_next.z_neg  = b1_item_reg.cam_z[CAM_W-1];
        side_next.z_zero = b1_item_reg.cam_z == '0;
        side_next.neg_u  = mx_reg[PROD_W-1] ^ b1_item_reg.cam_z[CAM_W-1];
        side_next.neg_v  = my_reg[PROD_W-1] ^ b1_item_reg.cam_z[CAM_W-1];
    end

    vtpc_div u_div_u (.clk(clk), .en(en), .dividend(mag_x), .divisor(mag_z),
                      .quotient(qu));
    vtpc_div u_div_v (.clk(clk), .en(en), .dividend(mag_y), .divisor(mag_z),
                      .quotient(qv));
    vtpc_div u_div_i (.clk(clk), .en(en), .dividend(INV_DIVIDEND), .divisor(mag_z),
                      .quotient(qi));

    // sideband travels alongside the divider stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k < DIV_STAGES; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign tail = side_reg[DIV_STAGES-1];

    // signed quotient plus centre, saturated to 32 bits; clamped inverse depth; zeroed when near-clipped
    always_comb
    begin
        su = tail.neg_u ? -$signed({4'b0, qu}) : $signed({4'b0, qu});
        sv = tail.neg_v ? -$signed({4'b0, qv}) : $signed({4'b0, qv});
        if (tail.z_zero)
        begin
            su = '0;
            sv = '0;
        end
        su = su + 60'($signed(cfg.center[31:0]));
        sv = sv + 60'($signed(cfg.center[63:32]));
        if (su > 60'sd2147483647)
            u_next = 32'sh7FFFFFFF;
        else if (su < -60'sd2147483648)
            u_next = 32'sh80000000;
        else
            u_next = su[31:0];
        if (sv > 60'sd2147483647)
            v_next = 32'sh7FFFFFFF;
        else if (sv < -60'sd2147483648)
            v_next = 32'sh80000000;
        else
            v_next = sv[31:0];
        priority if (tail.z_zero)
            inv_next = U32_MAX;
        else if (tail.z_neg)
            inv_next = '0;
        else if (qi > PROD_W'(U32_MAX))
            inv_next = U32_MAX;
        else
            inv_next = qi[31:0];
        if (tail.item.near)
        begin
            u_next   = '0;
            v_next   = '0;
            inv_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_item_reg <= tail.item;
            r1_u_reg    <= u_next;
            r1_v_reg    <= v_next;
            r1_inv_reg  <= inv_next;
        end
    end

    // side flags against the view rectangle
    always_comb
    begin
        if (r1_item_reg.near)
            flags_next = 5'b10000;
        else
        begin
            flags_next[4] = 1'b0;
            flags_next[0] = 33'(r1_u_reg) < $signed({1'b0, cfg.rect[15:0], 16'h0000});
            flags_next[1] = 33'(r1_v_reg) < $signed({1'b0, cfg.rect[31:16], 16'h0000});
            flags_next[2] = 33'(r1_u_reg) > $signed({1'b0, cfg.rect[47:32], 16'h0000});
            flags_next[3] = 33'(r1_v_reg) > $signed({1'b0, cfg.rect[63:48], 16'h0000});
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vtx_out.cam_x      <= r1_item_reg.cam_x;
            vtx_out.cam_y      <= r1_item_reg.cam_y;
            vtx_out.cam_z      <= r1_item_reg.cam_z;
            vtx_out.screen_u   <= r1_u_reg;
            vtx_out.screen_v   <= r1_v_reg;
            vtx_out.inv_depth  <= r1_inv_reg;
            vtx_out.clip_flags <= flags_next;
            vtx_out.light_out  <= r1_item_reg.light;
            vtx_out.tex_s      <= r1_item_reg.tex_s;
            vtx_out.tex_t      <= r1_item_reg.tex_t;
        end
    end

    assign vtx_out.valid = out_valid_reg;

endmodule

// ===== rtl/core/vertex_transform_project_clip.sv =====
// Vertex transform, perspective projection and clip outcodes, top level.
// Throughput: one vertex per cycle unless stalled; the 56-stage dividers are pipelined.
// Reset: asynchronous active low; clears pipelines and queue, loads register defaults.
// Depends on vtpc_pkg, vtpc_if, vtpc_front, vtpc_fifo, vtpc_back.
`timescale 1ns / 1ps
module vertex_transform_project_clip (
    input  logic                        clk,
    input  logic                        rst_n,
    vtpc_in_if.sink                     vtx_in,
    vtpc_out_if.source                  vtx_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vtpc_pkg::APB_AW-1:0] paddr,
    input  logic [vtpc_pkg::APB_DW-1:0] pwdata,
    output logic [vtpc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import vtpc_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic       push;
    item_t      push_item;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    item_t      q_head;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rot_x  <= 48'd16384;
            cfg_reg.rot_y  <= 48'd1073741824;
            cfg_reg.rot_z  <= 48'd70368744177664;
            cfg_reg.trans  <= '0;
            cfg_reg.scale  <= '0;
            cfg_reg.center <= '0;
            cfg_reg.rect   <= '0;
            cfg_reg.near   <= 24'd64;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ROT_X:  cfg_reg.rot_x  <= pwdata[47:0];
                REG_ROT_Y:  cfg_reg.rot_y  <= pwdata[47:0];
                REG_ROT_Z:  cfg_reg.rot_z  <= pwdata[47:0];
                REG_TRANS:  cfg_reg.trans  <= pwdata[59:0];
                REG_SCALE:  cfg_reg.scale  <= pwdata;
                REG_CENTER: cfg_reg.center <= pwdata;
                REG_RECT:   cfg_reg.rect   <= pwdata;
                REG_NEAR:   cfg_reg.near   <= pwdata[23:0];
                default:    ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_idx)
            REG_ROT_X:  prdata = 64'(cfg_reg.rot_x);
            REG_ROT_Y:  prdata = 64'(cfg_reg.rot_y);
            REG_ROT_Z:  prdata = 64'(cfg_reg.rot_z);
            REG_TRANS:  prdata = 64'(cfg_reg.trans);
            REG_SCALE:  prdata = cfg_reg.scale;
            REG_CENTER: prdata = cfg_reg.center;
            REG_RECT:   prdata = cfg_reg.rect;
            REG_NEAR:   prdata = 64'(cfg_reg.near);
            default:    prdata = '0;
        endcase
    end

    vtpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .vtx_in    (vtx_in),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    vtpc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    vtpc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_head  (q_head),
        .pop     (pop),
        .vtx_out (vtx_out)
    );

endmodule

// ===== verif/vtpc_checker.sv =====
// Checker for the vertex transform / projection / clip block: mirrors the
// register writes, predicts each projected vertex and compares the results.
// Depends on vtpc_pkg and vtpc_if.
`timescale 1ns / 1ps
module vtpc_checker
    import vtpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    vtpc_in_if                vtx_in,
    vtpc_out_if               vtx_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    output int                errors,
    output int                pending
);

    typedef struct packed {
        logic signed [23:0] cam_x;
        logic signed [23:0] cam_y;
        logic signed [23:0] cam_z;
        logic signed [31:0] screen_u;
        logic signed [31:0] screen_v;
        logic [31:0]        inv_depth;
        logic [4:0]         clip_flags;
        logic [15:0]        light_out;
        logic [25:0]        tex_s;
        logic [25:0]        tex_t;
    } proj_vtx_t;

    localparam logic [4:0] FLAG_LEFT   = 5'd1;
    localparam logic [4:0] FLAG_TOP    = 5'd2;
    localparam logic [4:0] FLAG_RIGHT  = 5'd4;
    localparam logic [4:0] FLAG_BOTTOM = 5'd8;
    localparam logic [4:0] FLAG_NEAR   = 5'd16;

    // mirrored register file
    logic [47:0] rot_x, rot_y, rot_z;
    logic [59:0] trans;
    logic [63:0] scale, center, rect;
    logic [23:0] near;

    proj_vtx_t projected_q[$];

    assign pending = projected_q.size();

    // one camera coordinate: Q.18 sum, round by 2^13, floor shift, saturate
    function automatic longint cam_coord(input logic [47:0] row, input longint px,
                                         input longint py, input longint pz,
                                         input logic [19:0] tr);
        longint acc;
        longint r;
        acc = longint'($signed(row[15:0])) * px + longint'($signed(row[31:16])) * py
            + longint'($signed(row[47:32])) * pz + longint'($signed(tr)) * 16384;
        r = (acc + 8192) >>> 14;
        if (r < -8388608) r = -8388608;
        if (r > 8388607)  r = 8388607;
        return r;
    endfunction

    function automatic longint screen_coord(input longint c, input logic [31:0] sc,
                                            input logic [31:0] ctr, input longint z);
        longint q;
        q = (z != 0) ? (c * longint'($signed(sc))) / z : 0;
        q = q + longint'($signed(ctr));
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        if (q > 64'sd2147483647)  q = 64'sd2147483647;
        return q;
    endfunction

    function automatic proj_vtx_t project_vertex(input logic [15:0] px, input logic [15:0] py,
                                                 input logic [15:0] pz, input logic [15:0] lt,
                                                 input logic [9:0] ss, input logic [9:0] st);
        proj_vtx_t r;
        longint cx, cy, cz, u, v, zi;
        cx = cam_coord(rot_x, $signed(px), $signed(py), $signed(pz), trans[19:0]);
        cy = cam_coord(rot_y, $signed(px), $signed(py), $signed(pz), trans[39:20]);
        cz = cam_coord(rot_z, $signed(px), $signed(py), $signed(pz), trans[59:40]);
        u = 0;
        v = 0;
        zi = 0;
        r.clip_flags = '0;
        if (cz < longint'($signed(near))) begin
            r.clip_flags = FLAG_NEAR;
        end
        else begin
            u = screen_coord(cx, scale[31:0], center[31:0], cz);
            v = screen_coord(cy, scale[63:32], center[63:32], cz);
            if (cz == 0) zi = 64'hFFFF_FFFF;
            else begin
                zi = (64'sd1 <<< 35) / cz;
                if (zi < 0) zi = 0;
                if (zi > 64'sh FFFF_FFFF) zi = 64'hFFFF_FFFF;
            end
            if (u < longint'(rect[15:0]) * 65536)  r.clip_flags |= FLAG_LEFT;
            if (v < longint'(rect[31:16]) * 65536) r.clip_flags |= FLAG_TOP;
            if (u > longint'(rect[47:32]) * 65536) r.clip_flags |= FLAG_RIGHT;
            if (v > longint'(rect[63:48]) * 65536) r.clip_flags |= FLAG_BOTTOM;
        end
        r.cam_x     = cx[23:0];
        r.cam_y     = cy[23:0];
        r.cam_z     = cz[23:0];
        r.screen_u  = u[31:0];
        r.screen_v  = v[31:0];
        r.inv_depth = zi[31:0];
        r.light_out = lt;
        r.tex_s     = 26'(ss[SKIN_COORD_BITS-1:0]) << 16;
        r.tex_t     = 26'(st[SKIN_COORD_BITS-1:0]) << 16;
        return r;
    endfunction

    function automatic int field_ok(input string name, input logic [63:0] exp_v,
                                    input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            return 0;
        end
        return 1;
    endfunction

    // register mirror, written on the APB access edge
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rot_x  <= 48'd16384;
            rot_y  <= 48'd1073741824;
            rot_z  <= 48'd70368744177664;
            trans  <= '0;
            scale  <= '0;
            center <= '0;
            rect   <= '0;
            near   <= 24'd64;
        end
        else if (psel && penable && pwrite && pready) begin
            case (paddr[5:3])
                REG_ROT_X:  rot_x  <= pwdata[47:0];
                REG_ROT_Y:  rot_y  <= pwdata[47:0];
                REG_ROT_Z:  rot_z  <= pwdata[47:0];
                REG_TRANS:  trans  <= pwdata[59:0];
                REG_SCALE:  scale  <= pwdata;
                REG_CENTER: center <= pwdata;
                REG_RECT:   rect   <= pwdata;
                REG_NEAR:   near   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // predict on accepted requests, compare on accepted results
    initial errors = 0;
    always @(posedge clk) begin
        proj_vtx_t e;
        int ok;
        if (rst_n && vtx_in.valid && vtx_in.ready)
            projected_q.push_back(project_vertex(vtx_in.pos_x, vtx_in.pos_y, vtx_in.pos_z,
                                                 vtx_in.light_in, vtx_in.skin_s,
                                                 vtx_in.skin_t));
        if (rst_n && vtx_out.valid && vtx_out.ready) begin
            if (projected_q.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end
            else begin
                e = projected_q.pop_front();
                ok = 1;
                ok &= field_ok("cam_x", e.cam_x, vtx_out.cam_x);
                ok &= field_ok("cam_y", e.cam_y, vtx_out.cam_y);
                ok &= field_ok("cam_z", e.cam_z, vtx_out.cam_z);
                ok &= field_ok("screen_u", e.screen_u, vtx_out.screen_u);
                ok &= field_ok("screen_v", e.screen_v, vtx_out.screen_v);
                ok &= field_ok("inv_depth", e.inv_depth, vtx_out.inv_depth);
                ok &= field_ok("clip_flags", e.clip_flags, vtx_out.clip_flags);
                ok &= field_ok("light_out", e.light_out, vtx_out.light_out);
                ok &= field_ok("tex_s", e.tex_s, vtx_out.tex_s);
                ok &= field_ok("tex_t", e.tex_t, vtx_out.tex_t);
                if (!ok) errors++;
            end
        end
    end

endmodule

// ===== verif/vertex_transform_project_clip_tb.sv =====
// Testbench top for vertex_transform_project_clip: clock, reset, APB
// register setup, vertex stimulus with bursts and stalls, and the verdict.
// Depends on vtpc_pkg, vtpc_if, the block and vtpc_checker.
`timescale 1ns / 1ps
module vertex_transform_project_clip_tb;
    import vtpc_pkg::*;

    localparam int PIPE_DRAIN = 80;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 280;

    logic              clk;
    logic              rst_n;
    logic              psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                errors, pending;
    int                cycles;
    int                sent;
    int                burst_left;
    int                stall_mode;
    logic              hold_off;
    logic              hold_req;

    vtpc_in_if  vtx_in();
    vtpc_out_if vtx_out();

    vertex_transform_project_clip uut (
        .clk(clk), .rst_n(rst_n), .vtx_in(vtx_in), .vtx_out(vtx_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    vtpc_checker chk (
        .clk(clk), .rst_n(rst_n), .vtx_in(vtx_in), .vtx_out(vtx_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver: stall pattern picked at random from four modes
    always @(posedge clk)
    begin
        if (cycles % 64 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: vtx_out.ready <= !hold_off;
            1: vtx_out.ready <= !hold_off && ($urandom_range(0, 1) == 1);
            2: vtx_out.ready <= !hold_off && ($urandom_range(0, 9) != 0);
            default: vtx_out.ready <= !hold_off && (cycles % 4 == 0);
        endcase
    end

    // long hold-off on the result side so the block backs up
    initial
    begin
        hold_off = 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_regs(input logic [47:0] rx, input logic [47:0] ry,
                            input logic [47:0] rz, input logic [59:0] tr,
                            input logic [63:0] sc, input logic [63:0] ct,
                            input logic [63:0] rc, input logic [23:0] np);
        reg_write(REG_ROT_X, 64'(rx));
        reg_write(REG_ROT_Y, 64'(ry));
        reg_write(REG_ROT_Z, 64'(rz));
        reg_write(REG_TRANS, 64'(tr));
        reg_write(REG_SCALE, sc);
        reg_write(REG_CENTER, ct);
        reg_write(REG_RECT, rc);
        reg_write(REG_NEAR, 64'(np));
    endtask

    // one request, with the sender's burst gaps in front of it
    task automatic send_vertex(input logic [15:0] px, input logic [15:0] py,
                               input logic [15:0] pz, input logic [15:0] lt,
                               input logic [9:0] ss, input logic [9:0] st);
        if (burst_left == 0)
        begin
            vtx_in.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
        end
        burst_left--;
        vtx_in.valid    <= 1'b1;
        vtx_in.pos_x    <= px;
        vtx_in.pos_y    <= py;
        vtx_in.pos_z    <= pz;
        vtx_in.light_in <= lt;
        vtx_in.skin_s   <= ss;
        vtx_in.skin_t   <= st;
        @(posedge clk);
        while (!vtx_in.ready) @(posedge clk);
        sent++;
    endtask

    // drop valid on the edge of the last request, then wait for the results
    task automatic drain;
        vtx_in.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    // mostly vertices in a modest box in front of the camera, some noise
    task automatic random_vertices(input int n, input int span);
        logic [15:0] px, py, pz;
        repeat (n)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                px = 16'($signed($urandom_range(0, 2 * span)) - span);
                py = 16'($signed($urandom_range(0, 2 * span)) - span);
                pz = 16'($urandom_range(0, span));
            end
            else
            begin
                px = 16'($urandom);
                py = 16'($urandom);
                pz = 16'($urandom);
            end
            send_vertex(px, py, pz, 16'($urandom), 10'($urandom), 10'($urandom));
        end
    endtask

    initial
    begin
        logic [47:0] r0, r1, r2;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        stall_mode = 0;
        sent = 0;
        burst_left = 0;
        vtx_in.valid = 1'b0;
        vtx_in.pos_x = '0;
        vtx_in.pos_y = '0;
        vtx_in.pos_z = '0;
        vtx_in.light_in = '0;
        vtx_in.skin_s = '0;
        vtx_in.skin_t = '0;
        vtx_out.ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset registers: extremes, near clipped and on the plane
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 10'h3FF, 10'h3FF);
        send_vertex(16'h8000, 16'h8000, 16'h8000, 16'h0000, 10'h000, 10'h000);
        send_vertex(16'h0000, 16'h0000, 16'h0000, 16'h5A5A, 10'h155, 10'h2AA);
        send_vertex(16'h8000, 16'h7FFF, 16'h0040, 16'hA5A5, 10'h2AA, 10'h155);
        send_vertex(16'h7FFF, 16'h8000, 16'h003F, 16'h0001, 10'h001, 10'h200);
        send_vertex(16'h0010, 16'hFFF0, 16'h0041, 16'h8000, 10'h200, 10'h001);
        drain();

        // directed, screen mapping with a view rectangle; zero and negative depth
        set_regs(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
                 {20'd0, 20'd0, 20'd0}, {32'h0100_0000, 32'h0100_0000},
                 {32'h0078_0000, 32'h00A0_0000}, {16'd240, 16'd320, 16'd0, 16'd0},
                 24'hFF_FF00);
        send_vertex(16'h0000, 16'h0000, 16'h0000, 16'h1234, 10'h3FF, 10'h000);
        send_vertex(16'h0100, 16'h0100, 16'h0000, 16'h1234, 10'h000, 10'h3FF);
        send_vertex(16'h0100, 16'hFF00, 16'hFFF8, 16'h4321, 10'h010, 10'h020);
        send_vertex(16'hFF00, 16'h0100, 16'h0001, 16'hFFFF, 10'h3FF, 10'h3FF);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h0010, 16'h0000, 10'h0AA, 10'h0BB);
        send_vertex(16'h8000, 16'h8000, 16'h0010, 16'h0000, 10'h0CC, 10'h0DD);
        send_vertex(16'h0000, 16'h0000, 16'h0100, 16'h0F0F, 10'h100, 10'h080);
        send_vertex(16'h0000, 16'h0000, 16'hFFFF, 16'hF0F0, 10'h040, 10'h020);
        drain();

        // phase: plain frustum, with the long result hold-off
        set_regs(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
                 {20'd1600, 20'd0, 20'd0}, {32'h0080_0000, 32'h0100_0000},
                 {32'h0078_0000, 32'h00A0_0000}, {16'd240, 16'd320, 16'd0, 16'd0},
                 24'd64);
        hold_req = 1'b1;
        random_vertices(PHASE_ITEMS, 4000);
        drain();

        // phase: random rotation and translation
        r0 = {16'($urandom_range(0, 32767) - 16384), 16'($urandom), 16'($urandom)};
        r1 = {16'($urandom), 16'($urandom), 16'($urandom)};
        r2 = {16'($urandom_range(8000, 24000)), 16'($urandom_range(0, 4000)),
              16'($urandom_range(0, 4000))};
        set_regs(r0, r1, r2, 60'({$urandom, $urandom}), {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, 24'($urandom_range(0, 4000)));
        random_vertices(PHASE_ITEMS, 16000);
        drain();

        // phase: saturating extremes, everything in front
        set_regs(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h7FFF_8000_7FFF,
                 60'hFFF_FFFF_FFFF_FFFF, {32'h8000_0000, 32'h7FFF_FFFF},
                 {32'h7FFF_FFFF, 32'h8000_0000}, 64'hFFFF_FFFF_FFFF_FFFF, 24'h80_0000);
        random_vertices(PHASE_ITEMS, 32767);
        drain();

        // phase: near plane at zero, flat depth row, many zero depths
        set_regs(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h0001_0000_0000,
                 {20'd0, 20'h80000, 20'h7FFFF}, {32'h0200_0000, 32'h0200_0000},
                 64'd0, {16'd100, 16'd100, 16'd10, 16'd10}, 24'd0);
        random_vertices(PHASE_ITEMS / 2, 64);
        drain();

        // phase: negative near plane, depths either side of zero
        set_regs(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
                 {20'hFFC00, 20'd0, 20'd0}, {32'hFF00_0000, 32'h0100_0000},
                 {32'h0078_0000, 32'h00A0_0000}, {16'd240, 16'd320, 16'd0, 16'd0},
                 24'hFF_F000);
        random_vertices(PHASE_ITEMS, 2000);
        drain();

        // phase: near plane at its maximum, every vertex clipped
        set_regs(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
                 60'd0, 64'd0, 64'd0, 64'd0, 24'h7F_FFFF);
        random_vertices(PHASE_ITEMS / 4, 32767);
        drain();

        // phase: every register random
        set_regs(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                 48'({$urandom, $urandom}), 60'({$urandom, $urandom}),
                 {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 24'($urandom));
        random_vertices(PHASE_ITEMS, 32767);
        drain();

        $display("Sent %0d vertices over nine register settings, including saturation,", sent);
        $display("zero and negative depth, full near clipping and a long output stall.");
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
